// ----- src/ctwp_pkg.sv -----
// ----------------------------------------------------------------------------
// ctwp_pkg: shared types and constants for the circle tile wall push-out
// Tile geometry, wall mask bit positions, corner codes and the item record
// that travels down the push-out pipeline.
// ----------------------------------------------------------------------------
package ctwp_pkg;

    localparam int TILE_Q   = 51200;
    localparam int TILE_SH  = 11;
    localparam int RECIP_M  = 41944;
    localparam int RECIP_SH = 20;

    localparam logic [2:0] BIT_NW = 3'd0;
    localparam logic [2:0] BIT_N  = 3'd1;
    localparam logic [2:0] BIT_NE = 3'd2;
    localparam logic [2:0] BIT_W  = 3'd3;
    localparam logic [2:0] BIT_E  = 3'd4;
    localparam logic [2:0] BIT_SW = 3'd5;
    localparam logic [2:0] BIT_S  = 3'd6;
    localparam logic [2:0] BIT_SE = 3'd7;

    localparam logic [1:0] CORNER_NW = 2'd0;
    localparam logic [1:0] CORNER_NE = 2'd1;
    localparam logic [1:0] CORNER_SW = 2'd2;
    localparam logic [1:0] CORNER_SE = 2'd3;

    typedef struct packed {
        logic signed [26:0] x;
        logic signed [23:0] y;
        logic signed [26:0] z;
        logic [24:0]        bx;
        logic [24:0]        bz;
        logic [14:0]        r;
        logic [7:0]         mask;
        logic               pushed;
    } item_t;

    function automatic logic [2:0] corner_bit(input logic [1:0] c);
        logic [2:0] b;
        case (c)
            CORNER_NW: b = BIT_NW;
            CORNER_NE: b = BIT_NE;
            CORNER_SW: b = BIT_SW;
            CORNER_SE: b = BIT_SE;
            default:   b = BIT_NW;
        endcase
        return b;
    endfunction

endpackage

// ----- src/ctwp_edge.sv -----
// ----------------------------------------------------------------------------
// ctwp_edge: tile lookup and edge wall clamps
// Finds the tile origin by reciprocal multiply, then clamps z against the
// north and south walls and x against the west and east walls.
// ----------------------------------------------------------------------------
module ctwp_edge
    import ctwp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [23:0]        pos_x,
    input  logic [23:0]        pos_y,
    input  logic [23:0]        pos_z,
    input  logic [14:0]        circle_radius,
    input  logic [7:0]         wall_mask,
    output logic               out_vld,
    output item_t              out_item
);

    localparam logic signed [26:0] TILE_S = 27'(TILE_Q);

    logic [4:0]  vld_reg;
    logic [23:0] x0_reg, y0_reg, z0_reg;
    logic [14:0] r0_reg;
    logic [7:0]  m0_reg;
    logic [8:0]  cx1_reg, cz1_reg, cx1_next, cz1_next;
    logic [23:0] x1_reg, y1_reg, z1_reg;
    logic [14:0] r1_reg;
    logic [7:0]  m1_reg;
    item_t       it2_reg, it2_next, it3_reg, it3_next, it4_reg, it4_next;

    logic [28:0] px_prod, pz_prod;
    logic signed [26:0] rs, gap;

    always_comb
    begin
        px_prod  = 29'(x0_reg[23:TILE_SH]) * 29'(RECIP_M);
        pz_prod  = 29'(z0_reg[23:TILE_SH]) * 29'(RECIP_M);
        cx1_next = px_prod[RECIP_SH +: 9];
        cz1_next = pz_prod[RECIP_SH +: 9];
    end

    always_comb
    begin
        it2_next.x      = $signed({3'b000, x1_reg});
        it2_next.y      = $signed(y1_reg);
        it2_next.z      = $signed({3'b000, z1_reg});
        it2_next.bx     = 25'(cx1_reg * 25'(TILE_Q));
        it2_next.bz     = 25'(cz1_reg * 25'(TILE_Q));
        it2_next.r      = r1_reg;
        it2_next.mask   = m1_reg;
        it2_next.pushed = 1'b0;
    end

    always_comb
    begin
        rs       = $signed({12'b0, it2_reg.r});
        it3_next = it2_reg;
        gap      = it3_next.z - $signed({2'b00, it2_reg.bz});
        if (it2_reg.mask[BIT_N] && gap < rs)
        begin
            it3_next.z      = $signed({2'b00, it2_reg.bz}) + rs;
            it3_next.pushed = 1'b1;
        end
        gap = $signed({2'b00, it2_reg.bz}) + TILE_S - it3_next.z;
        if (it2_reg.mask[BIT_S] && gap < rs)
        begin
            it3_next.z      = $signed({2'b00, it2_reg.bz}) + TILE_S - rs;
            it3_next.pushed = 1'b1;
        end
    end

    logic signed [26:0] rs3, gap3;

    always_comb
    begin
        rs3      = $signed({12'b0, it3_reg.r});
        it4_next = it3_reg;
        gap3     = it4_next.x - $signed({2'b00, it3_reg.bx});
        if (it3_reg.mask[BIT_W] && gap3 < rs3)
        begin
            it4_next.x      = $signed({2'b00, it3_reg.bx}) + rs3;
            it4_next.pushed = 1'b1;
        end
        gap3 = $signed({2'b00, it3_reg.bx}) + TILE_S - it4_next.x;
        if (it3_reg.mask[BIT_E] && gap3 < rs3)
        begin
            it4_next.x      = $signed({2'b00, it3_reg.bx}) + TILE_S - rs3;
            it4_next.pushed = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg  <= pos_x;
            y0_reg  <= pos_y;
            z0_reg  <= pos_z;
            r0_reg  <= circle_radius;
            m0_reg  <= wall_mask;
            cx1_reg <= cx1_next;
            cz1_reg <= cz1_next;
            x1_reg  <= x0_reg;
            y1_reg  <= y0_reg;
            z1_reg  <= z0_reg;
            r1_reg  <= r0_reg;
            m1_reg  <= m0_reg;
            it2_reg <= it2_next;
            it3_reg <= it3_next;
            it4_reg <= it4_next;
        end
    end

    assign out_vld  = vld_reg[4];
    assign out_item = it4_reg;

endmodule

// ----- src/ctwp_corner.sv -----
// ----------------------------------------------------------------------------
// ctwp_corner: pipelined push-out from one corner point
// Range check, squared distance, 2-bit-per-stage square root, 2-bit-per-stage
// division of each scaled offset component, then the corrected position.
// ----------------------------------------------------------------------------
module ctwp_corner
    import ctwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [1:0]  corner,
    input  logic        in_vld,
    input  item_t       in_item,
    output logic        out_vld,
    output item_t       out_item
);

    localparam int NST      = 25;
    localparam int SQ_FIRST = 3;
    localparam int SQ_LAST  = 14;
    localparam int DV_PREP  = 15;
    localparam int DV_FIRST = 16;
    localparam int DV_LAST  = 23;

    typedef struct packed {
        item_t            it;
        logic             cand;
        logic             fire;
        logic [2:0]       sg;
        logic [2:0][14:0] am;
        logic [2:0][29:0] sq;
        logic [29:0]      r2;
        logic [2:0][29:0] pr;
        logic [47:0]      rad;
        logic [26:0]      srem;
        logic [23:0]      root;
        logic [22:0]      len;
        logic [2:0][22:0] drem;
        logic [2:0][15:0] dnum;
        logic [2:0][15:0] quo;
    } cw_t;

    cw_t            st_reg  [NST];
    cw_t            st_next [NST];
    cw_t            in_cw;
    logic [NST-1:0] vld_reg;

    always_comb
    begin
        in_cw    = '0;
        in_cw.it = in_item;
    end

    always_comb
    begin
        cw_t                c;
        logic signed [26:0] cxc, czc;
        logic signed [26:0] d [3];
        logic [26:0]        dm;
        logic [31:0]        l2;
        logic [26:0]        w, t;
        logic [23:0]        wd;
        logic [38:0]        num;
        logic signed [26:0] qs;
        logic signed [26:0] nx, nz;
        logic signed [23:0] ny;
        for (int g = 0; g < NST; g++)
        begin
            c   = (g == 0) ? in_cw : st_reg[g-1];
            cxc = $signed({2'b00, c.it.bx}) + (corner[0] ? 27'(TILE_Q) : 27'sd0);
            czc = $signed({2'b00, c.it.bz}) + (corner[1] ? 27'(TILE_Q) : 27'sd0);
            if (g == 0)
            begin
                d[0]   = c.it.x - cxc;
                d[1]   = 27'(c.it.y);
                d[2]   = c.it.z - czc;
                c.cand = c.it.mask[corner_bit(corner)];
                for (int k = 0; k < 3; k++)
                begin
                    c.sg[k] = d[k][26];
                    dm      = c.sg[k] ? 27'(-d[k]) : 27'(d[k]);
                    if (dm >= {12'b0, c.it.r})
                    begin
                        c.cand = 1'b0;
                    end
                    c.am[k] = dm[14:0];
                end
            end
            else if (g == 1)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    c.sq[k] = c.am[k] * c.am[k];
                end
                c.r2 = c.it.r * c.it.r;
            end
            else if (g == 2)
            begin
                l2     = 32'(c.sq[0]) + 32'(c.sq[1]) + 32'(c.sq[2]);
                c.fire = c.cand && (l2 < {2'b00, c.r2}) && (l2 != 32'd0);
                c.rad  = {2'b00, l2[29:0], 16'h0000};
                c.srem = '0;
                c.root = '0;
                for (int k = 0; k < 3; k++)
                begin
                    c.pr[k] = c.am[k] * c.it.r;
                end
            end
            else if (g >= SQ_FIRST && g <= SQ_LAST)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    w = {c.srem[24:0], c.rad[47:46]};
                    t = {1'b0, c.root, 2'b01};
                    if (w >= t)
                    begin
                        c.srem = w - t;
                        c.root = {c.root[22:0], 1'b1};
                    end
                    else
                    begin
                        c.srem = w;
                        c.root = {c.root[22:0], 1'b0};
                    end
                    c.rad = {c.rad[45:0], 2'b00};
                end
            end
            else if (g == DV_PREP)
            begin
                c.len = c.root[22:0];
                for (int k = 0; k < 3; k++)
                begin
                    num       = {1'b0, c.pr[k], 8'h00} + {17'b0, c.len[22:1]};
                    c.drem[k] = num[38:16];
                    c.dnum[k] = num[15:0];
                    c.quo[k]  = '0;
                end
            end
            else if (g >= DV_FIRST && g <= DV_LAST)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        wd = {c.drem[k], c.dnum[k][15]};
                        if (wd >= {1'b0, c.len})
                        begin
                            c.drem[k] = 23'(wd - {1'b0, c.len});
                            c.quo[k]  = {c.quo[k][14:0], 1'b1};
                        end
                        else
                        begin
                            c.drem[k] = wd[22:0];
                            c.quo[k]  = {c.quo[k][14:0], 1'b0};
                        end
                        c.dnum[k] = {c.dnum[k][14:0], 1'b0};
                    end
                end
            end
            else
            begin
                qs = $signed({11'b0, c.quo[0]});
                nx = c.sg[0] ? cxc - qs : cxc + qs;
                qs = $signed({11'b0, c.quo[1]});
                ny = 24'(c.sg[1] ? -qs : qs);
                qs = $signed({11'b0, c.quo[2]});
                nz = c.sg[2] ? czc - qs : czc + qs;
                if (c.fire)
                begin
                    if (nx != c.it.x || ny != c.it.y || nz != c.it.z)
                    begin
                        c.it.pushed = 1'b1;
                    end
                    c.it.x = nx;
                    c.it.y = ny;
                    c.it.z = nz;
                end
            end
            st_next[g] = c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < NST; g++)
            begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_item = st_reg[NST-1].it;

endmodule

// ----- src/circle_tile_wall_pushout.sv -----
// ----------------------------------------------------------------------------
// circle_tile_wall_pushout: push a circle out of the walls around its tile
// Edge clamps (N, S, W, E) followed by corner push-outs (NW, NE, SW, SE).
// ----------------------------------------------------------------------------
// Takes one circle per clock cycle unless the pipeline holds, and returns one
// corrected position per circle, in order, after tile lookup and edge clamps,
// the four corner units (square root and division two bits per stage) and one
// output register. The whole pipeline holds while a finished result is not
// taken.
module circle_tile_wall_pushout
    import ctwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48], circle_radius[86:72],
    // wall_mask[94:87], zero[95]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_x[23:0], new_y[47:24], new_z[71:48], was_pushed[72], zero[79:73]
    output logic [79:0] m_tdata
);

    logic        en;
    logic        e_vld;
    item_t       e_item;
    logic [4:0]  c_vld;
    item_t       c_item [5];
    logic        out_vld_reg;
    logic [79:0] out_data_reg, out_data_next;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    ctwp_edge u_edge (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_vld        (s_tvalid),
        .pos_x         (s_tdata[23:0]),
        .pos_y         (s_tdata[47:24]),
        .pos_z         (s_tdata[71:48]),
        .circle_radius (s_tdata[86:72]),
        .wall_mask     (s_tdata[94:87]),
        .out_vld       (e_vld),
        .out_item      (e_item)
    );

    assign c_vld[0]  = e_vld;
    assign c_item[0] = e_item;

    ctwp_corner u_nw (.clk(clk), .rst_n(rst_n), .en(en), .corner(CORNER_NW),
        .in_vld(c_vld[0]), .in_item(c_item[0]), .out_vld(c_vld[1]), .out_item(c_item[1]));
    ctwp_corner u_ne (.clk(clk), .rst_n(rst_n), .en(en), .corner(CORNER_NE),
        .in_vld(c_vld[1]), .in_item(c_item[1]), .out_vld(c_vld[2]), .out_item(c_item[2]));
    ctwp_corner u_sw (.clk(clk), .rst_n(rst_n), .en(en), .corner(CORNER_SW),
        .in_vld(c_vld[2]), .in_item(c_item[2]), .out_vld(c_vld[3]), .out_item(c_item[3]));
    ctwp_corner u_se (.clk(clk), .rst_n(rst_n), .en(en), .corner(CORNER_SE),
        .in_vld(c_vld[3]), .in_item(c_item[3]), .out_vld(c_vld[4]), .out_item(c_item[4]));

    always_comb
    begin
        logic [23:0] sx, sz;
        if (c_item[4].x < 27'sd0)
        begin
            sx = '0;
        end
        else if (c_item[4].x > 27'sd16777215)
        begin
            sx = '1;
        end
        else
        begin
            sx = c_item[4].x[23:0];
        end
        if (c_item[4].z < 27'sd0)
        begin
            sz = '0;
        end
        else if (c_item[4].z > 27'sd16777215)
        begin
            sz = '1;
        end
        else
        begin
            sz = c_item[4].z[23:0];
        end
        out_data_next = {7'b0, c_item[4].pushed, sz, c_item[4].y, sx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= c_vld[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
